// ===== hdl/hashed_id_set_top_macros.svh =====
// Assertion macros for the RTL of the hashed id set top.
`ifndef HASHED_ID_SET_TOP_MACROS_SVH
`define HASHED_ID_SET_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define HIDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an expression is never true outside reset.
`define HIDS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== hdl/hids_pkg.sv =====
package hids_pkg;

  localparam int unsigned IdW      = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned LiveW    = 13;
  localparam int unsigned IdxBitsW = 4;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [IdW-1:0]      HashMult     = 32'd2654435761;
  localparam logic [IdxBitsW-1:0] IdxBitsReset = 4'd10;

  typedef enum logic [OpW-1:0] {
    OP_FIND   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } hids_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_CLEAR,
    ST_CLR_RSP
  } hids_state_e;

endpackage

// ===== hdl/hashed_id_set_top.sv =====
// Set of 32-bit ids held in a bucket memory of 2^BUCKET_BITS rows, each row holding WAYS
// id slots with their valid bits. The bucket of an id is the low index_bits bits of
// id * 2654435761 (modulo 2^32), with index_bits saturating at BUCKET_BITS. A find, add or
// remove first reads the bucket row from the memory, then compares all ways and writes the
// row back; the next item can be taken in the write-back step once the output is free, but
// not during the read. An add into a bucket with no free way is refused and flagged.
// A clear sweeps every row of the memory, one row per cycle, and returns its result once
// the output is free. After reset the same sweep runs over every row, during which no item
// is taken; configuration writes are taken at any time but must only be issued while the
// block is idle.
`include "hashed_id_set_top_macros.svh"

module hashed_id_set_top
  import hids_pkg::*;
#(
  parameter int unsigned BUCKET_BITS = 10,
  parameter int unsigned WAYS        = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxBitsW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: op[1:0], id[33:2], zero fill[39:34].
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: was_present[0], changed[1], bucket_full[2], live_count[15:3].
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned NumRows  = 2 ** BUCKET_BITS;
  localparam int unsigned NumSlots = NumRows * WAYS;
  localparam int unsigned CntW     = $clog2(NumSlots + 1);
  localparam int unsigned WayW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RowW     = WAYS * (IdW + 1);
  localparam logic [BUCKET_BITS-1:0] LastRow = {BUCKET_BITS{1'b1}};

  hids_state_e state_q, state_d;
  logic [IdxBitsW-1:0]    idx_bits_q;
  logic [BUCKET_BITS-1:0] sweep_q, sweep_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [BUCKET_BITS-1:0] bucket_q;
  logic [IdW-1:0]         id_q;
  hids_op_e               op_q;
  logic                   m_valid_q;
  logic [OutDataW-1:0]    m_data_q, m_data_d;

  logic                   in_accept;
  hids_op_e               in_op;
  logic [IdW-1:0]         in_id;
  logic [IdW-1:0]         hash;
  logic [BUCKET_BITS-1:0] mask;
  logic                   out_free;
  logic                   load_out;

  logic                   ram_we, ram_re;
  logic [BUCKET_BITS-1:0] ram_waddr;
  logic [RowW-1:0]        ram_wdata, ram_rdata, new_row;

  logic [WAYS-1:0]        hit_vec, free_vec;
  logic [WayW-1:0]        hit_idx, free_idx;
  logic                   present, do_add, do_rem, full;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_op     = hids_op_e'(s_axis_tdata[OpW-1:0]);
  assign in_id     = s_axis_tdata[OpW +: IdW];
  assign hash      = in_id * HashMult;
  assign out_free  = !m_valid_q || m_axis_tready;

  always_comb begin
    for (int i = 0; i < BUCKET_BITS; i++) begin
      mask[i] = 5'(i) < {1'b0, idx_bits_q};
    end
  end

  always_comb begin
    hit_vec  = '0;
    free_vec = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = ram_rdata[WAYS*IdW + w] && (ram_rdata[w*IdW +: IdW] == id_q);
      free_vec[w] = !ram_rdata[WAYS*IdW + w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = WayW'(w);
      end
      if (free_vec[w]) begin
        free_idx = WayW'(w);
      end
    end
    present = |hit_vec;
    do_add  = (op_q == OP_ADD) && !present && (|free_vec);
    full    = (op_q == OP_ADD) && !present && !(|free_vec);
    do_rem  = (op_q == OP_REMOVE) && present;
    new_row = ram_rdata;
    if (do_add) begin
      new_row[32'(free_idx)*IdW +: IdW]  = id_q;
      new_row[WAYS*IdW + 32'(free_idx)] = 1'b1;
    end
    if (do_rem) begin
      new_row[WAYS*IdW + 32'(hit_idx)] = 1'b0;
    end
  end

  always_comb begin
    state_d       = state_q;
    sweep_d       = sweep_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = sweep_q;
    ram_wdata     = '0;
    load_out      = 1'b0;
    m_data_d      = m_data_q;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == LastRow) begin
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_CLR_RSP;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_accept) begin
          state_d = (in_op == OP_CLEAR) ? ST_CLEAR : ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (out_free) begin
          s_axis_tready = 1'b1;
          load_out      = 1'b1;
          ram_we        = do_add || do_rem;
          ram_waddr     = bucket_q;
          ram_wdata     = new_row;
          if (do_add) begin
            cnt_d = cnt_q + 1'b1;
          end else if (do_rem) begin
            cnt_d = cnt_q - 1'b1;
          end
          m_data_d = {LiveW'(cnt_d), full, do_add || do_rem, present};
          if (in_accept) begin
            state_d = (in_op == OP_CLEAR) ? ST_CLEAR : ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CLR_RSP: begin
        if (out_free) begin
          load_out = 1'b1;
          cnt_d    = '0;
          m_data_d = {LiveW'(0), 1'b0, 1'b1, 1'b0};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      sweep_q    <= '0;
      cnt_q      <= '0;
      idx_bits_q <= IdxBitsReset;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        idx_bits_q <= cfg_wdata_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_op;
      id_q     <= in_id;
      bucket_q <= hash[BUCKET_BITS-1:0] & mask;
    end
    if (load_out) begin
      m_data_q <= m_data_d;
    end
  end

  hids_ram #(
    .Width(RowW),
    .Depth(NumRows)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(bucket_q),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `HIDS_ASSERT_NEVER(a_no_accept_in_sweep,
    (state_q == ST_INIT || state_q == ST_CLEAR) && s_axis_tready,
    "Item taken during a memory sweep.")
  `HIDS_ASSERT_NEVER(a_no_read_write_overlap, ram_we && ram_re,
    "Row memory read and written in the same cycle.")
  `HIDS_ASSERT(a_count_bound, cnt_q <= CntW'(NumSlots),
    "Live count exceeds the number of slots.")
  `HIDS_ASSERT_NEVER(a_full_without_change, load_out && m_data_d[2] && m_data_d[1],
    "Refused add reported as a change.")
  `HIDS_ASSERT(a_read_then_modify, state_q == ST_READ |=> state_q == ST_MODIFY,
    "Row read not followed by write-back.")

endmodule

// ===== hdl/hids_ram.sv =====
module hids_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
